/* sv/skvt_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// skvt_pkg
// Shared constants, controller states and control/status bundles for the
// sorted key/value table.
// ============================================================================
package skvt_pkg;

    localparam int DEF_CAPACITY = 256;
    localparam int KEY_W        = 32;
    localparam int VAL_W        = 16;
    localparam int ENTRY_W      = KEY_W + VAL_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SEARCH_CMP,
        ST_PROBE_CMP,
        ST_MISS,
        ST_SHIFT,
        ST_SHIFT_WR,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;      // capture item, lo = 0, hi = count
        logic rd_mid;    // read entry at midpoint
        logic step;      // narrow lo/hi from the midpoint compare
        logic rd_lo;     // read entry at lower bound
        logic idx_init;  // shift cursor = count
        logic rd_shift;  // read entry below cursor
        logic wr_shift;  // move read entry up to cursor, cursor--
        logic wr_new;    // write new pair at lower bound, count++
        logic res_hit;
        logic res_miss;
        logic res_full;
    } dp_cmd_t;

    typedef struct packed {
        logic lo_lt_hi;
        logic lo_lt_count;
        logic key_eq;
        logic is_insert;
        logic is_full;
        logic idx_gt_lo;
    } dp_status_t;

endpackage

/* sv/skvt_ram.sv */
`timescale 1ns / 1ps
// ============================================================================
// skvt_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module skvt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/skvt_ctrl.sv */
`timescale 1ns / 1ps
// ============================================================================
// skvt_ctrl
// Sequencer for search, probe, shift and result phases.
// ============================================================================
module skvt_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  skvt_pkg::dp_status_t   status,
    output skvt_pkg::dp_cmd_t      cmd,
    output logic                   busy,
    output logic                   done
);
    import skvt_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                priority if (status.lo_lt_hi)
                begin
                    state_next = ST_SEARCH_CMP;
                end
                else if (status.lo_lt_count)
                begin
                    state_next = ST_PROBE_CMP;
                end
                else
                begin
                    state_next = ST_MISS;
                end
            end
            ST_SEARCH_CMP: state_next = ST_SEARCH;
            ST_PROBE_CMP:  state_next = status.key_eq ? ST_DONE : ST_MISS;
            ST_MISS:
            begin
                if (status.is_insert && !status.is_full)
                begin
                    state_next = ST_SHIFT;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SHIFT:      state_next = status.idx_gt_lo ? ST_SHIFT_WR : ST_DONE;
            ST_SHIFT_WR:   state_next = ST_SHIFT;
            ST_DONE:       state_next = ST_IDLE;
            default:       state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = (state_reg != ST_IDLE);
        done = (state_reg == ST_DONE);
        unique case (state_reg)
            ST_IDLE:       cmd.load = start;
            ST_SEARCH:
            begin
                cmd.rd_mid = status.lo_lt_hi;
                cmd.rd_lo  = !status.lo_lt_hi;
            end
            ST_SEARCH_CMP: cmd.step = 1'b1;
            ST_PROBE_CMP:  cmd.res_hit = status.key_eq;
            ST_MISS:
            begin
                priority if (!status.is_insert)
                begin
                    cmd.res_miss = 1'b1;
                end
                else if (status.is_full)
                begin
                    cmd.res_full = 1'b1;
                end
                else
                begin
                    cmd.idx_init = 1'b1;
                end
            end
            ST_SHIFT:
            begin
                cmd.rd_shift = status.idx_gt_lo;
                cmd.wr_new   = !status.idx_gt_lo;
                cmd.res_miss = !status.idx_gt_lo;
            end
            ST_SHIFT_WR:   cmd.wr_shift = 1'b1;
            ST_DONE:       cmd = '0;
            default:       cmd = '0;
        endcase
    end

endmodule

/* sv/skvt_dp.sv */
`timescale 1ns / 1ps
// ============================================================================
// skvt_dp
// Datapath: item registers, search bounds, shift cursor, entry count,
// entry RAM and result registers.
// ============================================================================
module skvt_dp #(
    parameter int CAPACITY = skvt_pkg::DEF_CAPACITY
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  skvt_pkg::dp_cmd_t             cmd,
    output skvt_pkg::dp_status_t          status,
    input  logic                          command,
    input  logic signed [skvt_pkg::KEY_W-1:0] key,
    input  logic [skvt_pkg::VAL_W-1:0]    entry_value,
    output logic                          found,
    output logic [skvt_pkg::VAL_W-1:0]    read_value,
    output logic                          table_full
);
    import skvt_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    logic              cmd_reg;
    logic signed [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0]  val_reg;
    logic [CW-1:0]     lo_reg, lo_next;
    logic [CW-1:0]     hi_reg, hi_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              found_reg;
    logic [VAL_W-1:0]  rv_reg;
    logic              full_reg;

    logic [CW-1:0]     mid;
    logic [CW-1:0]     idx_m1;
    logic [AW-1:0]     raddr;
    logic [AW-1:0]     waddr;
    logic [ENTRY_W-1:0] wdata;
    logic              we;
    logic [ENTRY_W-1:0] rdata;
    logic signed [KEY_W-1:0] rd_key;
    logic [VAL_W-1:0]  rd_val;

    assign mid    = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign idx_m1 = idx_reg - CW'(1);
    assign rd_key = $signed(rdata[ENTRY_W-1:VAL_W]);
    assign rd_val = rdata[VAL_W-1:0];

    always_comb
    begin
        priority if (cmd.rd_mid)
        begin
            raddr = mid[AW-1:0];
        end
        else if (cmd.rd_lo)
        begin
            raddr = lo_reg[AW-1:0];
        end
        else
        begin
            raddr = idx_m1[AW-1:0];
        end
    end

    always_comb
    begin
        we    = cmd.wr_shift | cmd.wr_new;
        waddr = cmd.wr_shift ? idx_reg[AW-1:0] : lo_reg[AW-1:0];
        wdata = cmd.wr_shift ? rdata : {key_reg, val_reg};
    end

    skvt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_entry_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        idx_next   = idx_reg;
        count_next = count_reg;
        if (cmd.load)
        begin
            lo_next = '0;
            hi_next = count_reg;
        end
        if (cmd.step)
        begin
            if (rd_key < key_reg)
            begin
                lo_next = mid + CW'(1);
            end
            else
            begin
                hi_next = mid;
            end
        end
        if (cmd.idx_init)
        begin
            idx_next = count_reg;
        end
        if (cmd.wr_shift)
        begin
            idx_next = idx_m1;
        end
        if (cmd.wr_new)
        begin
            count_next = count_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            lo_reg    <= '0;
            hi_reg    <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg <= command;
            key_reg <= key;
            val_reg <= entry_value;
        end
        priority if (cmd.res_hit)
        begin
            found_reg <= 1'b1;
            rv_reg    <= rd_val;
            full_reg  <= 1'b0;
        end
        else if (cmd.res_full)
        begin
            found_reg <= 1'b0;
            rv_reg    <= '0;
            full_reg  <= 1'b1;
        end
        else if (cmd.res_miss)
        begin
            found_reg <= 1'b0;
            rv_reg    <= '0;
            full_reg  <= 1'b0;
        end
    end

    always_comb
    begin
        status.lo_lt_hi    = (lo_reg < hi_reg);
        status.lo_lt_count = (lo_reg < count_reg);
        status.key_eq      = (rd_key == key_reg);
        status.is_insert   = cmd_reg;
        status.is_full     = (count_reg == CAP_C);
        status.idx_gt_lo   = (idx_reg > lo_reg);
    end

    assign found      = found_reg;
    assign read_value = rv_reg;
    assign table_full = full_reg;

endmodule

/* sv/sorted_key_value_table.sv */
`timescale 1ns / 1ps
// ============================================================================
// sorted_key_value_table
// Sorted key/value table with binary-search lookup and ordered insert.
// ============================================================================
// An item is taken when start is high and busy is low; busy stays high until
// its result has been shown. The result appears on found/read_value/
// table_full for exactly one cycle with done high and cannot be held off.
// Each binary-search step reads the midpoint entry from the registered-read
// entry RAM and then compares it with the key; the entry at the lower bound
// is then probed for a match. An insert of a new key reads each entry to be
// shifted up and then writes it one slot higher before writing the new pair.
// ============================================================================
module sorted_key_value_table #(
    parameter int CAPACITY = skvt_pkg::DEF_CAPACITY
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              command,
    input  logic signed [skvt_pkg::KEY_W-1:0] key,
    input  logic [skvt_pkg::VAL_W-1:0]        entry_value,
    output logic                              done,
    output logic                              found,
    output logic [skvt_pkg::VAL_W-1:0]        read_value,
    output logic                              table_full
);
    import skvt_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    skvt_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    skvt_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .command     (command),
        .key         (key),
        .entry_value (entry_value),
        .found       (found),
        .read_value  (read_value),
        .table_full  (table_full)
    );

endmodule

/* tb/sorted_key_value_table_test.sv */
`timescale 1ns / 1ps
// ============================================================================
// sorted_key_value_table_test
// Self-checking testbench for the sorted key/value table.
// ============================================================================
// Items go in through the start/busy handshake. Each accepted item is
// applied to a local copy of the sorted table, and the expected reply is
// queued. Every done strobe is then compared with the oldest queued reply.
// Stimulus runs in this order: directed corner cases on a nearly empty table,
// random mixed traffic while the table grows, a fill to capacity, full-table
// corner cases, and more random traffic on the full table.
// ============================================================================

localparam int TBL_CAP = skvt_pkg::DEF_CAPACITY;

localparam bit CMD_LOOKUP = 1'b0;
localparam bit CMD_INSERT = 1'b1;

typedef struct {
    logic                          found;
    logic [skvt_pkg::VAL_W-1:0]    value;
    logic                          full;
} table_reply_t;

class kv_table_model;
    logic signed [skvt_pkg::KEY_W-1:0] keys [TBL_CAP];
    logic [skvt_pkg::VAL_W-1:0]        vals [TBL_CAP];
    int                                count;
    table_reply_t                      pending_replies [$];
    int                                errors;

    function new();
        count  = 0;
        errors = 0;
    endfunction

    task report_mismatch(string msg);
        if (errors < 50)
            $display("MISMATCH at %0t: %s", $realtime, msg);
        errors++;
    endtask

    // first index whose key is >= k, or count when there is none
    function int first_not_below(logic signed [skvt_pkg::KEY_W-1:0] k);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = count;
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (keys[mid] < k)
                lo = mid + 1;
            else
                hi = mid;
        end
        return lo;
    endfunction

    function bit holds(logic signed [skvt_pkg::KEY_W-1:0] k);
        int pos;
        pos = first_not_below(k);
        return pos < count && keys[pos] == k;
    endfunction

    function void accept_request(bit cmd, logic signed [skvt_pkg::KEY_W-1:0] k,
                                 logic [skvt_pkg::VAL_W-1:0] v);
        table_reply_t reply;
        int           pos;
        pos         = first_not_below(k);
        reply.found = 1'b0;
        reply.value = '0;
        reply.full  = 1'b0;
        if (pos < count && keys[pos] == k)
        begin
            reply.found = 1'b1;
            reply.value = vals[pos];
        end
        else if (cmd == CMD_INSERT)
        begin
            if (count >= TBL_CAP)
            begin
                reply.full = 1'b1;
            end
            else
            begin
                for (int i = count; i > pos; i--)
                begin
                    keys[i] = keys[i-1];
                    vals[i] = vals[i-1];
                end
                keys[pos] = k;
                vals[pos] = v;
                count++;
            end
        end
        pending_replies = {pending_replies, reply};
    endfunction

    task check_reply(logic f, logic [skvt_pkg::VAL_W-1:0] rv, logic full);
        table_reply_t want;
        if (pending_replies.size() == 0)
        begin
            report_mismatch("result strobe with no item outstanding");
            return;
        end
        want = pending_replies.pop_front();
        if (f !== want.found)
            report_mismatch($sformatf("found %b, expected %b", f, want.found));
        if (rv !== want.value)
            report_mismatch($sformatf("read_value %h, expected %h", rv, want.value));
        if (full !== want.full)
            report_mismatch($sformatf("table_full %b, expected %b", full, want.full));
    endtask
endclass

module sorted_key_value_table_test;

    logic                              clk = 1'b0;
    logic                              rst_n;
    logic                              start;
    logic                              busy;
    logic                              command;
    logic signed [skvt_pkg::KEY_W-1:0] key;
    logic [skvt_pkg::VAL_W-1:0]        entry_value;
    logic                              done;
    logic                              found;
    logic [skvt_pkg::VAL_W-1:0]        read_value;
    logic                              table_full;

    localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] KEY_MAX = 32'sh7fff_ffff;
    localparam int                 ITEM_TARGET = 700;

    kv_table_model model = new();
    int            items_sent = 0;
    int            burst_left = 0;

    sorted_key_value_table i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .command     (command),
        .key         (key),
        .entry_value (entry_value),
        .done        (done),
        .found       (found),
        .read_value  (read_value),
        .table_full  (table_full)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            model.check_reply(found, read_value, table_full);
    end

    function automatic int pick_gap();
        int r;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            burst_left = $urandom_range(10, 40);
            return 0;
        end
        if (r < 40) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // about half the keys near the current contents so hits and ordered inserts happen
    function automatic logic signed [31:0] pick_key();
        int r;
        r = $urandom_range(0, 9);
        if (model.count > 0 && r < 4)
            return model.keys[$urandom_range(0, model.count - 1)];
        if (model.count > 0 && r == 4)
            return model.keys[$urandom_range(0, model.count - 1)]
                   + ($urandom_range(0, 1) ? 32'sd1 : -32'sd1);
        if (r == 5)
        begin
            case ($urandom_range(0, 4))
                0: return KEY_MIN;
                1: return KEY_MAX;
                2: return 32'sd0;
                3: return -32'sd1;
                default: return 32'sd1;
            endcase
        end
        return $urandom;
    endfunction

    task automatic send_request(input bit cmd, input logic signed [31:0] k,
                                input logic [15:0] v);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start       <= 1'b1;
        command     <= cmd;
        key         <= k;
        entry_value <= v;
        do @(posedge clk); while (busy);
        model.accept_request(cmd, k, v);
        items_sent++;
    endtask

    task automatic send_random(input int insert_pct);
        bit cmd;
        cmd = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_LOOKUP;
        send_request(cmd, pick_key(), 16'($urandom));
    endtask

    // hold off new items until every reply is back
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (model.pending_replies.size() != 0) @(negedge clk);
    endtask

    initial
    begin
        logic signed [31:0] absent;
        rst_n       = 1'b0;
        start       = 1'b0;
        command     = CMD_LOOKUP;
        key         = '0;
        entry_value = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty table, extremes, duplicates, misses next to stored keys
        send_request(CMD_LOOKUP, 32'sd0, 16'h0000);
        send_request(CMD_INSERT, KEY_MIN, 16'h0000);
        send_request(CMD_INSERT, KEY_MAX, 16'hffff);
        send_request(CMD_INSERT, 32'sd0, 16'h1234);
        send_request(CMD_INSERT, -32'sd1, 16'haaaa);
        send_request(CMD_INSERT, 32'sd1, 16'h5555);
        send_request(CMD_LOOKUP, KEY_MIN, 16'hffff);
        send_request(CMD_LOOKUP, KEY_MAX, 16'h0000);
        send_request(CMD_LOOKUP, 32'sd0, 16'h0000);
        send_request(CMD_LOOKUP, -32'sd1, 16'h0000);
        send_request(CMD_LOOKUP, 32'sd1, 16'h0000);
        send_request(CMD_INSERT, KEY_MAX, 16'h0000);
        send_request(CMD_INSERT, KEY_MIN, 16'hffff);
        send_request(CMD_LOOKUP, KEY_MIN + 32'sd1, 16'hffff);
        send_request(CMD_LOOKUP, KEY_MAX - 32'sd1, 16'h0000);
        send_request(CMD_INSERT, 32'sh8000_0001, 16'h8001);
        send_request(CMD_LOOKUP, 32'sh8000_0001, 16'h0000);
        send_request(CMD_INSERT, 32'sh7fff_fffe, 16'h7ffe);
        send_request(CMD_LOOKUP, 32'sh7fff_fffe, 16'h0000);
        drain();

        // table grows under mixed traffic
        for (int i = 0; i < 400; i++)
        begin
            send_random(55);
            if (i % 100 == 99)
                drain();
        end

        while (model.count < TBL_CAP)
            send_request(CMD_INSERT, $urandom, 16'($urandom));
        drain();

        // full table: refused new key, duplicate insert, lookups at both ends
        do absent = $urandom; while (model.holds(absent));
        send_request(CMD_INSERT, absent, 16'hbeef);
        send_request(CMD_LOOKUP, absent, 16'h0000);
        send_request(CMD_INSERT, model.keys[0], 16'h0f0f);
        send_request(CMD_INSERT, model.keys[TBL_CAP-1], 16'hf0f0);
        send_request(CMD_LOOKUP, model.keys[0], 16'h0000);
        send_request(CMD_LOOKUP, model.keys[TBL_CAP-1], 16'h0000);
        if (!model.holds(KEY_MIN))
            send_request(CMD_INSERT, KEY_MIN + 32'sd2, 16'h1111);

        while (items_sent < ITEM_TARGET)
        begin
            send_random(40);
            if (items_sent % 150 == 0)
                drain();
        end

        drain();
        repeat (40) @(posedge clk);
        if (model.pending_replies.size() != 0)
            model.report_mismatch("replies still outstanding at end of run");
        if (model.errors == 0)
            $display("sorted_key_value_table test passed");
        else
            $display("sorted_key_value_table test failed");
        $finish;
    end

    initial
    begin
        #25_000_000;
        $display("sorted_key_value_table test failed");
        $finish;
    end

endmodule
